// File: sv/eulr_pkg.sv
// Package: widths, lane and item types and polynomial constants of the Euler rotation block.
package eulr_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 16;
  localparam int Q          = 30;
  localparam int U_W        = Q + 1;
  localparam int ACC_W      = 34;
  localparam int SC_W       = 32;
  localparam int P_W        = 64;
  localparam int N_LANE     = 6;
  localparam int N_ANG      = 3;
  localparam int N_CELL     = 5;
  localparam int N_STG      = N_CELL + 5;

  localparam logic [U_W-1:0] ONE_U = U_W'(1) << Q;

  // c9, c7, c5, c3, c1 of the quarter-wave sine polynomial, Q30
  localparam logic signed [ACC_W-1:0] POLY_COEF [N_CELL] = '{
    34'sd172272, -34'sd5026995, 34'sd85569306, -34'sd693598668, 34'sd1686629713
  };

  typedef struct packed {
    logic [U_W-1:0]          u;
    logic [U_W-1:0]          t2;
    logic signed [ACC_W-1:0] acc;
  } lane_t;

  typedef struct packed {
    lane_t [N_LANE-1:0]      lane;
    logic  [N_ANG-1:0][1:0]  quad;
  } item_t;

  typedef logic signed [OUT_W-1:0] ent_t;

  typedef struct packed {
    ent_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } mat_t;

endpackage

// File: sv/eulr_if.sv
// Interfaces: input angle channel and result matrix channel.
interface eulr_in_if;
  logic                        valid;
  logic                        ready;
  logic [eulr_pkg::IN_W-1:0]   angle_x;
  logic [eulr_pkg::IN_W-1:0]   angle_y;
  logic [eulr_pkg::IN_W-1:0]   angle_z;
  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface eulr_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [eulr_pkg::OUT_W-1:0]  m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

// File: sv/eulr_cell.sv
// Horner cell: acc = coef + round(acc * m) on all six sine lanes, registered.
module eulr_cell (
  input  logic                             clk,
  input  logic                             en,
  input  eulr_pkg::item_t                  d,
  input  logic signed [eulr_pkg::ACC_W-1:0] coef,
  input  logic                             use_u,
  output eulr_pkg::item_t                  q_r
);
  import eulr_pkg::*;

  localparam int PROD_W = ACC_W + U_W + 1;
  localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) << (Q - 1);

  logic [U_W-1:0]           mul_b [N_LANE];
  logic signed [PROD_W-1:0] prod  [N_LANE];
  logic signed [PROD_W-1:0] rnd   [N_LANE];
  item_t                    q_nxt;

  // multiply, round half up to Q30, add the coefficient
  always_comb begin
    q_nxt = d;
    for (int l = 0; l < N_LANE; l++) begin
      mul_b[l] = use_u ? d.lane[l].u : d.lane[l].t2;
      prod[l]  = $signed(d.lane[l].acc) * $signed({1'b0, mul_b[l]});
      rnd[l]   = (prod[l] + RND) >>> Q;
      q_nxt.lane[l].acc = coef + rnd[l][ACC_W-1:0];
    end
  end

  // advance
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

// File: sv/eulr_mat.sv
// Matrix stages: fold sine/cosine by quadrant, form products, sum, round and saturate.
module eulr_mat (
  input  logic            clk,
  input  logic            en,
  input  eulr_pkg::item_t d,
  output eulr_pkg::mat_t  q_r
);
  import eulr_pkg::*;

  localparam logic signed [P_W-1:0] RND30 = P_W'(1) << (Q - 1);
  localparam logic signed [P_W-1:0] RNDE  = P_W'(1) << (59 - FRAC_BITS);
  localparam logic signed [P_W-1:0] LIM   = P_W'(1) << FRAC_BITS;

  function automatic logic signed [SC_W-1:0] clamp_q30(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] one;
    one = ACC_W'(ONE_U);
    if (a < 0) return '0;
    else if (a > one) return SC_W'(ONE_U);
    else return a[SC_W-1:0];
  endfunction

  function automatic ent_t to_entry(input logic signed [P_W-1:0] v);
    logic signed [P_W-1:0] e;
    e = (v + RNDE) >>> (60 - FRAC_BITS);
    if (e > LIM) e = LIM;
    if (e < -LIM) e = -LIM;
    return e[OUT_W-1:0];
  endfunction

  logic signed [SC_W-1:0] s [N_ANG];
  logic signed [SC_W-1:0] c [N_ANG];
  logic signed [SC_W-1:0] sp, cp;

  // stage 1 registers: raw Q60 products and sin y
  logic signed [P_W-1:0]  cxcz_r, cxsz_r, sxcz_r, sxsz_r, cycz_r, cysz_r, sxcy_r, cxcy_r;
  logic signed [SC_W-1:0] sy_r;
  // stage 2 registers: rounded pairs plus carried values
  logic signed [SC_W+1:0] rcc_r, rcs_r, rsc_r, rss_r;
  logic signed [P_W-1:0]  cxcz2_r, cxsz2_r, sxcz2_r, sxsz2_r, cycz2_r, cysz2_r;
  logic signed [P_W-1:0]  sxcy2_r, cxcy2_r;
  logic signed [SC_W-1:0] sy2_r;
  // stage 3 registers: Q60 sums
  logic signed [P_W-1:0]  v_r [9];

  // fold quarter-wave values into full-turn sine and cosine
  always_comb begin
    sp = '0;
    cp = '0;
    for (int k = 0; k < N_ANG; k++) begin
      sp = clamp_q30(d.lane[2*k].acc);
      cp = clamp_q30(d.lane[2*k+1].acc);
      case (d.quad[k])
        2'd0:    begin s[k] = sp;  c[k] = cp;  end
        2'd1:    begin s[k] = cp;  c[k] = -sp; end
        2'd2:    begin s[k] = -sp; c[k] = -cp; end
        default: begin s[k] = -cp; c[k] = sp;  end
      endcase
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      cxcz_r <= P_W'(c[0]) * P_W'(c[2]);
      cxsz_r <= P_W'(c[0]) * P_W'(s[2]);
      sxcz_r <= P_W'(s[0]) * P_W'(c[2]);
      sxsz_r <= P_W'(s[0]) * P_W'(s[2]);
      cycz_r <= P_W'(c[1]) * P_W'(c[2]);
      cysz_r <= P_W'(c[1]) * P_W'(s[2]);
      sxcy_r <= P_W'(s[0]) * P_W'(c[1]);
      cxcy_r <= P_W'(c[0]) * P_W'(c[1]);
      sy_r   <= s[1];
    end
  end

  // round the paired products to Q30
  always_ff @(posedge clk) begin
    if (en) begin
      rcc_r   <= (SC_W + 2)'((cxcz_r + RND30) >>> Q);
      rcs_r   <= (SC_W + 2)'((cxsz_r + RND30) >>> Q);
      rsc_r   <= (SC_W + 2)'((sxcz_r + RND30) >>> Q);
      rss_r   <= (SC_W + 2)'((sxsz_r + RND30) >>> Q);
      cxcz2_r <= cxcz_r;
      cxsz2_r <= cxsz_r;
      sxcz2_r <= sxcz_r;
      sxsz2_r <= sxsz_r;
      cycz2_r <= cycz_r;
      cysz2_r <= cysz_r;
      sxcy2_r <= sxcy_r;
      cxcy2_r <= cxcy_r;
      sy2_r   <= sy_r;
    end
  end

  // sum entries at Q60
  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0] <= cycz2_r;
      v_r[1] <= P_W'(rsc_r) * P_W'(sy2_r) - cxsz2_r;
      v_r[2] <= sxsz2_r + P_W'(rcc_r) * P_W'(sy2_r);
      v_r[3] <= cysz2_r;
      v_r[4] <= cxcz2_r + P_W'(rss_r) * P_W'(sy2_r);
      v_r[5] <= P_W'(rcs_r) * P_W'(sy2_r) - sxcz2_r;
      v_r[6] <= -(P_W'(sy2_r) <<< Q);
      v_r[7] <= sxcy2_r;
      v_r[8] <= cxcy2_r;
    end
  end

  // round and saturate into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      q_r.m00 <= to_entry(v_r[0]);
      q_r.m01 <= to_entry(v_r[1]);
      q_r.m02 <= to_entry(v_r[2]);
      q_r.m10 <= to_entry(v_r[3]);
      q_r.m11 <= to_entry(v_r[4]);
      q_r.m12 <= to_entry(v_r[5]);
      q_r.m20 <= to_entry(v_r[6]);
      q_r.m21 <= to_entry(v_r[7]);
      q_r.m22 <= to_entry(v_r[8]);
    end
  end

endmodule

// File: sv/euler_xyz_rotation_matrix.sv
// Top level: Euler XYZ angles to 3x3 rotation matrix, fully pipelined.
// One item per cycle enters and leaves; the stages are one front stage (quadrant
// split and phase squaring), a chain of five Horner cells evaluating six quarter-wave
// sines in parallel, and four matrix stages (fold and products, pair rounding, sums,
// round/saturate). The whole pipeline holds while a finished result waits on out_ch.ready.
module euler_xyz_rotation_matrix (
  input  logic  clk,
  input  logic  rst_n,
  eulr_in_if.sink    in_ch,
  eulr_out_if.source out_ch
);
  import eulr_pkg::*;

  localparam int EXT_W = 32;
  localparam logic [2*U_W-1:0] RND_T2 = (2*U_W)'(1) << (Q - 1);

  logic              en;
  logic [N_STG-1:0]  vld_r;
  logic [IN_W-1:0]   ang [N_ANG];
  logic [EXT_W-1:0]  ext [N_ANG];
  logic [U_W-1:0]    u   [N_LANE];
  logic [2*U_W-1:0]  sq  [N_LANE];
  item_t             front_nxt, front_r;
  item_t             chain [N_CELL+1];
  mat_t              mat_q;

  assign en          = !vld_r[N_STG-1] || out_ch.ready;
  assign in_ch.ready = en;

  assign ang[0] = in_ch.angle_x;
  assign ang[1] = in_ch.angle_y;
  assign ang[2] = in_ch.angle_z;

  // split angles into quadrant and phase; square the phase
  always_comb begin
    front_nxt = '0;
    for (int k = 0; k < N_ANG; k++) begin
      ext[k] = EXT_W'(ang[k]);
      front_nxt.quad[k] = ext[k][ANGLE_BITS-1 -: 2];
      u[2*k]   = U_W'(ext[k][ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
      u[2*k+1] = ONE_U - u[2*k];
    end
    for (int l = 0; l < N_LANE; l++) begin
      sq[l] = (2*U_W)'(u[l]) * (2*U_W)'(u[l]);
      front_nxt.lane[l].u   = u[l];
      front_nxt.lane[l].t2  = U_W'((sq[l] + RND_T2) >> Q);
      front_nxt.lane[l].acc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front_r <= front_nxt;
    end
  end

  // track valid items through the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N_STG-2:0], in_ch.valid};
    end
  end

  // Horner chain; the first cell seeds with c9, the last multiplies by the phase
  assign chain[0] = front_r;

  for (genvar i = 0; i < N_CELL; i++) begin : g_cell
    logic signed [ACC_W-1:0] coef;
    item_t                   cin;
    always_comb begin
      cin = chain[i];
      if (i == 0) begin
        for (int l = 0; l < N_LANE; l++) begin
          cin.lane[l].acc = POLY_COEF[0];
        end
      end
    end
    assign coef = (i == N_CELL - 1) ? '0 : POLY_COEF[i+1];
    eulr_cell u_cell (
      .clk   (clk),
      .en    (en),
      .d     (cin),
      .coef  (coef),
      .use_u (i == N_CELL - 1),
      .q_r   (chain[i+1])
    );
  end

  eulr_mat u_mat (
    .clk (clk),
    .en  (en),
    .d   (chain[N_CELL]),
    .q_r (mat_q)
  );

  assign out_ch.valid = vld_r[N_STG-1];
  assign out_ch.m00   = mat_q.m00;
  assign out_ch.m01   = mat_q.m01;
  assign out_ch.m02   = mat_q.m02;
  assign out_ch.m10   = mat_q.m10;
  assign out_ch.m11   = mat_q.m11;
  assign out_ch.m12   = mat_q.m12;
  assign out_ch.m20   = mat_q.m20;
  assign out_ch.m21   = mat_q.m21;
  assign out_ch.m22   = mat_q.m22;

endmodule

// File: tb/sv/euler_xyz_rotation_matrix_test.sv
// Testbench for the Euler XYZ rotation matrix block: directed table, random angles, predictor check.
module euler_xyz_rotation_matrix_test;
  import eulr_pkg::*;

  typedef struct {
    logic [IN_W-1:0] ax, ay, az;
    bit              has_known;
    mat_t            known;
  } stim_row_t;

  localparam int N_RANDOM = 400;
  localparam int LATENCY  = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count = 0;
  bit   sender_done = 1'b0;
  mat_t pending_mats[$];

  eulr_in_if  in_ch();
  eulr_out_if out_ch();

  euler_xyz_rotation_matrix i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #1 clk = ~clk;

  // Round half up by sh bits
  function automatic longint rnd_shift(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return rnd_shift(a * b, Q);
  endfunction

  // Quarter-wave sine: phase u in Q30, result clamped to [0, 1.0]
  function automatic longint quarter_sin(longint u);
    longint t2, p;
    t2 = q30_mul(u, u);
    p  = POLY_COEF[0];
    for (int i = 1; i < N_CELL; i++) p = POLY_COEF[i] + q30_mul(p, t2);
    p = q30_mul(p, u);
    if (p < 0) p = 0;
    if (p > (longint'(1) << Q)) p = longint'(1) << Q;
    return p;
  endfunction

  function automatic void angle_sin_cos(logic [IN_W-1:0] ang, output longint s,
                                        output longint c);
    logic [ANGLE_BITS-1:0] a;
    longint u, sp, cp;
    a  = ang[ANGLE_BITS-1:0];
    u  = longint'(a[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
    sp = quarter_sin(u);
    cp = quarter_sin((longint'(1) << Q) - u);
    case (a[ANGLE_BITS-1 -: 2])
      2'd0: begin s = sp;  c = cp;  end
      2'd1: begin s = cp;  c = -sp; end
      2'd2: begin s = -sp; c = -cp; end
      default: begin s = -cp; c = sp; end
    endcase
  endfunction

  // Q60 sum to saturated output entry
  function automatic ent_t q60_to_entry(longint v);
    longint e, lim;
    lim = longint'(1) << FRAC_BITS;
    e   = rnd_shift(v, 60 - FRAC_BITS);
    if (e > lim) e = lim;
    if (e < -lim) e = -lim;
    return ent_t'(e);
  endfunction

  function automatic mat_t rotation_of(logic [IN_W-1:0] ax, ay, az);
    longint sx, cx, sy, cy, sz, cz, cxcz, cxsz, sxcz, sxsz;
    mat_t m;
    angle_sin_cos(ax, sx, cx);
    angle_sin_cos(ay, sy, cy);
    angle_sin_cos(az, sz, cz);
    cxcz = q30_mul(cx, cz);
    cxsz = q30_mul(cx, sz);
    sxcz = q30_mul(sx, cz);
    sxsz = q30_mul(sx, sz);
    m.m00 = q60_to_entry(cy * cz);
    m.m01 = q60_to_entry(sxcz * sy - cx * sz);
    m.m02 = q60_to_entry(sx * sz + cxcz * sy);
    m.m10 = q60_to_entry(cy * sz);
    m.m11 = q60_to_entry(cx * cz + sxsz * sy);
    m.m12 = q60_to_entry(cxsz * sy - sx * cz);
    m.m20 = q60_to_entry(-sy * (longint'(1) << Q));
    m.m21 = q60_to_entry(sx * cy);
    m.m22 = q60_to_entry(cx * cy);
    return m;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic mat_t id_mat();
    mat_t m;
    m = '0;
    m.m00 = 16'sd16384; m.m11 = 16'sd16384; m.m22 = 16'sd16384;
    return m;
  endfunction

  // Directed table: identity, quarter turns, extremes, wrap points
  stim_row_t directed_rows[$];

  function automatic stim_row_t mk_row(logic [IN_W-1:0] ax, ay, az);
    stim_row_t r;
    r.ax = ax; r.ay = ay; r.az = az; r.has_known = 1'b0; r.known = '0;
    return r;
  endfunction

  task automatic send_angles(logic [IN_W-1:0] ax, ay, az);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.angle_x <= ax;
    in_ch.angle_y <= ay;
    in_ch.angle_z <= az;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender
  initial begin
    stim_row_t r;
    logic [IN_W-1:0] a3[3];
    in_ch.valid = 1'b0;
    in_ch.angle_x = '0; in_ch.angle_y = '0; in_ch.angle_z = '0;
    r = mk_row(16'h0000, 16'h0000, 16'h0000);
    r.has_known = 1'b1; r.known = id_mat();
    directed_rows.push_back(r);
    directed_rows.push_back(mk_row(16'h4000, 16'h0000, 16'h0000));
    directed_rows.push_back(mk_row(16'h0000, 16'h4000, 16'h0000));
    directed_rows.push_back(mk_row(16'h0000, 16'h0000, 16'h4000));
    directed_rows.push_back(mk_row(16'h8000, 16'h8000, 16'h8000));
    directed_rows.push_back(mk_row(16'hC000, 16'hC000, 16'hC000));
    directed_rows.push_back(mk_row(16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed_rows.push_back(mk_row(16'h0001, 16'h3FFF, 16'h4001));
    directed_rows.push_back(mk_row(16'h7FFF, 16'hBFFF, 16'h8001));
    directed_rows.push_back(mk_row(16'h2000, 16'h6000, 16'hA000));
    directed_rows.push_back(mk_row(16'hE000, 16'h5555, 16'hAAAA));
    directed_rows.push_back(mk_row(16'h4000, 16'h4000, 16'h4000));
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      pending_mats.push_back(r.has_known ? r.known : rotation_of(r.ax, r.ay, r.az));
      send_angles(r.ax, r.ay, r.az);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      // Hold off once until the pipeline drains
      if (n == N_RANDOM / 2) begin
        in_ch.valid <= 1'b0;
        while (pending_mats.size() != 0) @(negedge clk);
      end
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 5))
          0: a3[k] = 16'($urandom_range(0, 3)) << 14;
          1: a3[k] = (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 3)) - 16'd1;
          default: a3[k] = 16'($urandom);
        endcase
      end
      pending_mats.push_back(rotation_of(a3[0], a3[1], a3[2]));
      send_angles(a3[0], a3[1], a3[2]);
    end
    in_ch.valid <= 1'b0;
    sender_done = 1'b1;
  end

  // Receiver stalls
  initial begin
    int g;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 2) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_ch.ready <= 1'b0;
          repeat (g) @(negedge clk);
        end
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic check_entry(string nm, ent_t exp_v, ent_t got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0d, got %0d", nm, exp_v, got_v);
      fail_count++;
    end
  endtask

  // Compare each accepted result with the oldest expected matrix
  always @(posedge clk) begin
    mat_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_mats.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
      end else begin
        e = pending_mats.pop_front();
        check_entry("m00", e.m00, out_ch.m00);
        check_entry("m01", e.m01, out_ch.m01);
        check_entry("m02", e.m02, out_ch.m02);
        check_entry("m10", e.m10, out_ch.m10);
        check_entry("m11", e.m11, out_ch.m11);
        check_entry("m12", e.m12, out_ch.m12);
        check_entry("m20", e.m20, out_ch.m20);
        check_entry("m21", e.m21, out_ch.m21);
        check_entry("m22", e.m22, out_ch.m22);
      end
    end
  end

  // End of run
  initial begin
    wait (sender_done);
    while (pending_mats.size() != 0) @(posedge clk);
    repeat (LATENCY * 4) @(posedge clk);
    if (fail_count == 0 && pending_mats.size() == 0) begin
      $display("euler_xyz_rotation_matrix verification clean");
    end else begin
      $display("euler_xyz_rotation_matrix verification failed");
    end
    $finish;
  end

  // Timeout
  initial begin
    #200000;
    $display("euler_xyz_rotation_matrix verification failed");
    $finish;
  end

endmodule

// File: euler_xyz_rotation_matrix.f
sv/eulr_pkg.sv
sv/eulr_if.sv
sv/eulr_cell.sv
sv/eulr_mat.sv
sv/euler_xyz_rotation_matrix.sv
tb/sv/euler_xyz_rotation_matrix_test.sv
